>>> rtl/core/srtf_pkg.sv
package srtf_pkg;

    // Default table geometry
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_MAX_HOPS      = 8;

    // Fixed field widths
    localparam int KEY_W  = 32;
    localparam int HOP_W  = 32;
    localparam int IDX_W  = 3;
    localparam int LEN_W  = 4;
    localparam int NH_W   = 4;
    localparam int KIND_W = 2;

    // Input item modes
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WORD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DECIDE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

    // Header values written by a fresh lookup
    localparam logic [NH_W-1:0]  NH_AFTER_LOOKUP = 4'd1;
    localparam logic [NH_W-1:0]  NH_WORD         = 4'd2;
    localparam logic [LEN_W-1:0] PL_MISS         = 4'd1;

    typedef struct packed {
        logic              mode;
        logic [KEY_W-1:0]  dest_forwarder;
        logic [31:0]       final_dest_ip;
        logic [NH_W-1:0]   next_hop_in;
        logic [LEN_W-1:0]  path_length_in;
        logic [HOP_W-1:0]  carried_hop;
        logic [IDX_W-1:0]  hop_index;
        logic [LEN_W-1:0]  route_length;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  word_index;
        logic [31:0]       word_value;
        logic [LEN_W-1:0]  path_length_out;
        logic [NH_W-1:0]   next_hop_out;
        logic              to_final;
        logic              hop_error;
        logic              last;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_SCAN,
        ST_UPD,
        ST_CSCAN,
        ST_ACK,
        ST_NAK,
        ST_EMIT,
        ST_MISS,
        ST_DEC
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_WORD,
        RES_MISS,
        RES_DECIDE,
        RES_COMMIT,
        RES_REJECT
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     scan_start;
        logic     scan_run;
        logic     scan_inval;
        logic     set_slot;
        logic     upd;
        logic     lookup_set;
        logic     hop_first;
        logic     hop_emit;
        t_res_sel res_sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_update;
        logic idx_zero;
        logic nh_zero;
        logic commit_pt;
        logic upd_ok;
        logic match_found;
        logic scan_end;
        logic hit_len_zero;
        logic last_word;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/srtf_ctrl.sv
module srtf_ctrl
    import srtf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    logic scan_done;
    assign scan_done = i_sts.match_found || i_sts.scan_end;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISP;
            end
            ST_DISP: begin
                if (i_sts.is_update) begin
                    n_state = i_sts.idx_zero ? ST_SCAN : ST_UPD;
                end else begin
                    n_state = i_sts.nh_zero ? ST_SCAN : ST_DEC;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    if (i_sts.is_update) begin
                        n_state = ST_UPD;
                    end else if (i_sts.match_found) begin
                        n_state = i_sts.hit_len_zero ? ST_DEC : ST_EMIT;
                    end else begin
                        n_state = ST_MISS;
                    end
                end
            end
            ST_UPD: begin
                if (i_sts.commit_pt) begin
                    n_state = i_sts.upd_ok ? ST_CSCAN : ST_NAK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CSCAN: begin
                if (i_sts.scan_end) n_state = ST_ACK;
            end
            ST_ACK, ST_NAK, ST_DEC: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.last_word) n_state = ST_DEC;
            end
            ST_MISS: begin
                if (i_sts.out_free) n_state = ST_DEC;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = RES_NONE;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DISP: begin
                o_cmd.scan_start = i_sts.is_update ? i_sts.idx_zero : i_sts.nh_zero;
            end
            ST_SCAN: begin
                if (scan_done) begin
                    o_cmd.set_slot   = i_sts.is_update;
                    o_cmd.lookup_set = !i_sts.is_update;
                    o_cmd.hop_first  = !i_sts.is_update && i_sts.match_found
                                       && !i_sts.hit_len_zero;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            ST_UPD: begin
                o_cmd.upd        = 1'b1;
                o_cmd.scan_start = i_sts.commit_pt && i_sts.upd_ok;
            end
            ST_CSCAN: begin
                o_cmd.scan_run   = !i_sts.scan_end;
                o_cmd.scan_inval = !i_sts.scan_end;
            end
            ST_ACK: begin
                if (i_sts.out_free) o_cmd.res_sel = RES_COMMIT;
            end
            ST_NAK: begin
                if (i_sts.out_free) o_cmd.res_sel = RES_REJECT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.hop_emit = 1'b1;
                    o_cmd.res_sel  = RES_WORD;
                end
            end
            ST_MISS: begin
                if (i_sts.out_free) o_cmd.res_sel = RES_MISS;
            end
            ST_DEC: begin
                if (i_sts.out_free) o_cmd.res_sel = RES_DECIDE;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/srtf_dp.sv
module srtf_dp
    import srtf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int MAX_HOPS      = DEF_MAX_HOPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int SLOT_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCAN_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int HOP_DEPTH = TABLE_ENTRIES * MAX_HOPS;
    localparam int HADDR_W   = (HOP_DEPTH > 1) ? $clog2(HOP_DEPTH) : 1;
    localparam int MH_W      = $clog2(MAX_HOPS + 1);
    localparam int CMP_W     = (MH_W > LEN_W) ? MH_W : LEN_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } t_entry;

    // Latched item and header working values
    t_in_word           r_in;
    logic [NH_W-1:0]    r_nh;
    logic [LEN_W-1:0]   r_pl;
    logic [HOP_W-1:0]   r_word;
    logic [LEN_W-1:0]   r_cnt;

    // Route table
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry             r_kmem [TABLE_ENTRIES];
    t_entry             r_kmem_q;
    logic [HOP_W-1:0]   r_hmem [HOP_DEPTH];
    logic [HOP_W-1:0]   r_hop_q;

    // Scan engine
    logic [SCAN_W-1:0]  r_scan_addr;
    logic               r_cmp_valid;
    logic [SLOT_W-1:0]  r_cmp_idx;
    logic               r_match_found;
    logic [SLOT_W-1:0]  r_match_idx;
    logic [LEN_W-1:0]   r_match_len;
    logic               r_free_found;
    logic [SLOT_W-1:0]  r_free_idx;

    // Update in progress
    logic [SLOT_W-1:0]  r_slot;
    logic               r_ok;

    // Output register
    logic               r_out_valid;
    t_out_word          r_out;
    t_out_word          n_out;

    logic [LEN_W-1:0]   eff;
    logic [LEN_W-1:0]   commit_at;
    logic               commit_pt;
    logic               hop_wr;
    logic               do_commit;
    logic [HADDR_W-1:0] wr_addr;
    logic [HADDR_W-1:0] rd_addr;
    logic [LEN_W-1:0]   rd_idx;
    logic               rd_en;
    logic               last_word;
    logic               scan_end;
    logic               scan_rd;
    logic               cmp_hit;
    logic               cmp_free;
    logic               fin;
    logic               err;
    logic               out_free;
    logic               load;

    // Effective route length and commit point
    assign eff = (CMP_W'(r_in.route_length) < CMP_W'(MAX_HOPS))
                 ? r_in.route_length : LEN_W'(MAX_HOPS);
    assign commit_at = (eff == '0) ? '0 : eff - 1'b1;
    assign commit_pt = (LEN_W'(r_in.hop_index) == commit_at);
    assign hop_wr    = r_ok && (LEN_W'(r_in.hop_index) < eff);
    assign do_commit = i_cmd.upd && commit_pt && r_ok;

    // Hop memory addresses
    assign wr_addr   = HADDR_W'(r_slot) * HADDR_W'(MAX_HOPS) + HADDR_W'(r_in.hop_index);
    assign rd_idx    = i_cmd.hop_first ? '0 : r_cnt + 1'b1;
    assign rd_addr   = HADDR_W'(r_match_idx) * HADDR_W'(MAX_HOPS) + HADDR_W'(rd_idx);
    assign last_word = ({1'b0, r_cnt} + 5'd1) >= {1'b0, r_pl};
    assign rd_en     = i_cmd.hop_first || (i_cmd.hop_emit && !last_word);

    // Key compare on the registered table read
    assign scan_end = (r_scan_addr == SCAN_W'(TABLE_ENTRIES)) && !r_cmp_valid;
    assign scan_rd  = i_cmd.scan_run && (r_scan_addr != SCAN_W'(TABLE_ENTRIES));
    assign cmp_hit  = r_cmp_valid && r_valid[r_cmp_idx]
                      && (r_kmem_q.key == r_in.dest_forwarder);
    assign cmp_free = r_cmp_valid && !r_valid[r_cmp_idx];

    // Forward decision
    assign fin = (r_nh != '0) && ((r_nh - 1'b1) == r_pl);
    assign err = {1'b0, r_nh} > ({1'b0, r_pl} + 5'd1);

    assign out_free = !r_out_valid || i_out_ready;
    assign load     = (i_cmd.res_sel != RES_NONE);

    // Build the result word
    always_comb begin
        n_out = '0;
        case (i_cmd.res_sel)
            RES_WORD: begin
                n_out.kind            = KIND_WORD;
                n_out.word_index      = r_cnt[IDX_W-1:0];
                n_out.word_value      = r_hop_q;
                n_out.path_length_out = r_pl;
                n_out.next_hop_out    = NH_WORD;
            end
            RES_MISS: begin
                n_out.kind            = KIND_WORD;
                n_out.word_value      = r_in.dest_forwarder;
                n_out.path_length_out = r_pl;
                n_out.next_hop_out    = NH_WORD;
            end
            RES_DECIDE: begin
                n_out.kind            = KIND_DECIDE;
                n_out.word_value      = fin ? r_in.final_dest_ip : r_word;
                n_out.path_length_out = r_pl;
                n_out.next_hop_out    = r_nh + 1'b1;
                n_out.to_final        = fin;
                n_out.hop_error       = err;
                n_out.last            = 1'b1;
            end
            RES_COMMIT: begin
                n_out.kind            = KIND_COMMIT;
                n_out.path_length_out = eff;
                n_out.last            = 1'b1;
            end
            RES_REJECT: begin
                n_out.kind            = KIND_REJECT;
                n_out.last            = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Control state: valid bits, scan progress, update slot, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_ok          <= 1'b0;
            r_slot        <= '0;
            r_scan_addr   <= '0;
            r_cmp_valid   <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.scan_start) begin
                r_scan_addr   <= '0;
                r_cmp_valid   <= 1'b0;
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_cmp_valid <= scan_rd;
                if (scan_rd) r_scan_addr <= r_scan_addr + 1'b1;
                if (cmp_hit) r_match_found <= 1'b1;
                if (cmp_free) r_free_found <= 1'b1;
                // drop older entries that carry the committed key
                if (i_cmd.scan_inval && cmp_hit && (r_cmp_idx != r_slot)) begin
                    r_valid[r_cmp_idx] <= 1'b0;
                end
            end

            if (i_cmd.set_slot) begin
                r_ok <= r_match_found || r_free_found;
                if (r_match_found) begin
                    r_slot <= r_match_idx;
                end else if (r_free_found) begin
                    r_slot <= r_free_idx;
                end
            end

            if (i_cmd.upd && commit_pt) r_ok <= 1'b0;
            if (do_commit) r_valid[r_slot] <= 1'b1;
        end
    end

    // Payload: item latch, scan records, header values, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in   <= i_in_data;
            r_nh   <= i_in_data.next_hop_in;
            r_pl   <= i_in_data.path_length_in;
            r_word <= i_in_data.carried_hop;
        end
        if (scan_rd) r_cmp_idx <= r_scan_addr[SLOT_W-1:0];
        if (i_cmd.scan_run && cmp_hit && !r_match_found) begin
            r_match_idx <= r_cmp_idx;
            r_match_len <= r_kmem_q.len;
        end
        if (i_cmd.scan_run && cmp_free && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_cmd.lookup_set) begin
            r_nh <= NH_AFTER_LOOKUP;
            if (r_match_found) begin
                r_pl <= r_match_len;
            end else begin
                r_pl   <= PL_MISS;
                r_word <= r_in.dest_forwarder;
            end
        end
        if (i_cmd.hop_first) r_cnt <= '0;
        if (i_cmd.hop_emit) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == '0) r_word <= r_hop_q;
        end
        if (load) r_out <= n_out;
    end

    // Key and length table
    always_ff @(posedge i_clk) begin
        if (do_commit) begin
            r_kmem[r_slot] <= '{key: r_in.dest_forwarder, len: eff};
        end
        if (scan_rd) r_kmem_q <= r_kmem[r_scan_addr[SLOT_W-1:0]];
    end

    // Hop table
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && hop_wr) r_hmem[wr_addr] <= r_in.carried_hop;
        if (rd_en) r_hop_q <= r_hmem[rd_addr];
    end

    assign o_sts.is_update    = (r_in.mode == MODE_UPDATE);
    assign o_sts.idx_zero     = (r_in.hop_index == '0);
    assign o_sts.nh_zero      = (r_in.next_hop_in == '0);
    assign o_sts.commit_pt    = commit_pt;
    assign o_sts.upd_ok       = r_ok;
    assign o_sts.match_found  = r_match_found;
    assign o_sts.scan_end     = scan_end;
    assign o_sts.hit_len_zero = (r_match_len == '0);
    assign o_sts.last_word    = last_word;
    assign o_sts.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/source_route_table_forwarder_top.sv
// Source-route table forwarder.
// Input channel (i_in_valid / o_in_ready, word i_in_data) takes route-update
// hops and packet headers; output channel (o_out_valid / i_out_ready, word
// o_out_data) returns path words, forward decisions and update acknowledges,
// the final word of each item flagged with last.
// One item is worked at a time. A packet that already carries a path goes
// from accept through dispatch straight to its decision. A packet needing a
// lookup first sweeps the key table, one table entry per cycle, ending early
// on a hit, then emits its path words, one word per cycle while the receiver
// is ready, then the decision. A non-first update hop is accepted, dispatched
// and written; a first hop adds a sweep for its slot, and a commit adds a full
// sweep to retire older entries of that key, then the result.
// Results pass through one output register: a new word is loaded in the same
// cycle that the current one is taken, and a stalled receiver holds the block in place.
// Reset clears all table valid bits and any update in progress; no sweep runs.
module source_route_table_forwarder_top
    import srtf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int MAX_HOPS      = DEF_MAX_HOPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    t_cmd cmd;
    t_sts sts;

    srtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    srtf_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_HOPS      (MAX_HOPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.res_sel != RES_NONE) |-> sts.out_free)
        else $error("result loaded into a full output register");

    // The closing result of an item returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.res_sel == RES_DECIDE || cmd.res_sel == RES_COMMIT
         || cmd.res_sel == RES_REJECT) |=> o_in_ready)
        else $error("block not idle after closing result");

    // A commit ends the update in progress
    a_commit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.upd && sts.commit_pt) |=> !sts.upd_ok)
        else $error("update still open after commit");

endmodule

>>> tb/source_route_table_forwarder_top_tb.sv
module source_route_table_forwarder_top_tb;
    import srtf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
    localparam int MAX_HOPS      = DEF_MAX_HOPS;
    localparam int KEY_POOL      = 10;
    localparam int RANDOM_TARGET = 185;
    localparam int DRAIN_CYCLES  = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    source_route_table_forwarder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Shadow route table
    bit          route_valid [TABLE_ENTRIES];
    logic [31:0] route_key   [TABLE_ENTRIES];
    int          route_len   [TABLE_ENTRIES];
    logic [31:0] route_hops  [TABLE_ENTRIES][MAX_HOPS];
    bit          hop_written [TABLE_ENTRIES][MAX_HOPS];
    int          upd_slot;
    bit          upd_ok;

    t_out_word   due_words[$];
    t_out_word   want;
    logic [31:0] route_keys [KEY_POOL];

    int  fails;
    int  items_sent;
    int  lookup_hits;
    int  path_words_seen;
    int  decisions_seen;
    int  commits_seen;
    int  rejects_seen;
    bit  quiet;
    int  ready_hold;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Stall length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_in_word rand_word();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word mk_packet(logic [31:0] dest, logic [31:0] fip,
                                           int nh, int pl, logic [31:0] word);
        t_in_word w;
        w = rand_word();
        w.mode           = MODE_PACKET;
        w.dest_forwarder = dest;
        w.final_dest_ip  = fip;
        w.next_hop_in    = NH_W'(nh);
        w.path_length_in = LEN_W'(pl);
        w.carried_hop    = word;
        return w;
    endfunction

    function automatic t_in_word mk_hop(logic [31:0] key, logic [31:0] hop, int idx, int len);
        t_in_word w;
        w = rand_word();
        w.mode           = MODE_UPDATE;
        w.dest_forwarder = key;
        w.carried_hop    = hop;
        w.hop_index      = IDX_W'(idx);
        w.route_length   = LEN_W'(len);
        return w;
    endfunction

    // A hit must never read a path position that no update wrote
    function automatic bit lookup_safe(logic [31:0] dest);
        int s;
        int h;
        for (s = 0; s < TABLE_ENTRIES; s++) begin
            if (route_valid[s] && route_key[s] == dest) begin
                for (h = 0; h < route_len[s]; h++)
                    if (!hop_written[s][h])
                        return 1'b0;
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic int free_count();
        int s;
        int n;
        n = 0;
        for (s = 0; s < TABLE_ENTRIES; s++)
            if (!route_valid[s])
                n++;
        return n;
    endfunction

    // Append one result word to the expected list
    task automatic queue_due(input t_out_word r);
        due_words = {due_words, r};
    endtask

    // Work out the result words of one accepted word and queue them
    task automatic predict_forward(input t_in_word w);
        t_out_word   r;
        int          s;
        int          h;
        int          eff;
        int          commit_at;
        int          idx;
        int          hit;
        int          nh;
        int          pl;
        logic [31:0] word;
        bit          found;

        if (w.mode == MODE_UPDATE) begin
            eff       = (w.route_length < MAX_HOPS) ? int'(w.route_length) : MAX_HOPS;
            commit_at = (eff == 0) ? 0 : eff - 1;
            idx       = int'(w.hop_index);
            // First hop picks the matching slot, else the first free one
            if (idx == 0) begin
                found = 1'b0;
                for (s = 0; s < TABLE_ENTRIES && !found; s++)
                    if (route_valid[s] && route_key[s] == w.dest_forwarder) begin
                        upd_slot = s;
                        found    = 1'b1;
                    end
                for (s = 0; s < TABLE_ENTRIES && !found; s++)
                    if (!route_valid[s]) begin
                        upd_slot = s;
                        found    = 1'b1;
                    end
                upd_ok = found;
            end
            if (upd_ok && idx < eff) begin
                route_hops[upd_slot][idx]  = w.carried_hop;
                hop_written[upd_slot][idx] = 1'b1;
            end
            if (idx == commit_at) begin
                r      = '0;
                r.last = 1'b1;
                if (upd_ok) begin
                    for (s = 0; s < TABLE_ENTRIES; s++)
                        if (s != upd_slot && route_valid[s] && route_key[s] == w.dest_forwarder)
                            route_valid[s] = 1'b0;
                    route_key[upd_slot]   = w.dest_forwarder;
                    route_len[upd_slot]   = eff;
                    route_valid[upd_slot] = 1'b1;
                    r.kind                = KIND_COMMIT;
                    r.path_length_out     = LEN_W'(eff);
                end else begin
                    r.kind = KIND_REJECT;
                end
                upd_ok = 1'b0;
                queue_due(r);
            end
        end else begin
            nh   = int'(w.next_hop_in);
            pl   = int'(w.path_length_in);
            word = w.carried_hop;
            // Fresh packet: fill the path from the table or point at the forwarder
            if (nh == 0) begin
                hit = -1;
                for (s = 0; s < TABLE_ENTRIES; s++)
                    if (hit < 0 && route_valid[s] && route_key[s] == w.dest_forwarder)
                        hit = s;
                nh = 1;
                if (hit >= 0) begin
                    lookup_hits++;
                    pl   = route_len[hit];
                    word = (pl > 0) ? route_hops[hit][0] : 32'd0;
                    for (h = 0; h < pl; h++) begin
                        r                 = '0;
                        r.kind            = KIND_WORD;
                        r.word_index      = IDX_W'(h);
                        r.word_value      = route_hops[hit][h];
                        r.path_length_out = LEN_W'(pl);
                        r.next_hop_out    = NH_WORD;
                        queue_due(r);
                    end
                end else begin
                    pl                = int'(PL_MISS);
                    word              = w.dest_forwarder;
                    r                 = '0;
                    r.kind            = KIND_WORD;
                    r.word_value      = w.dest_forwarder;
                    r.path_length_out = PL_MISS;
                    r.next_hop_out    = NH_WORD;
                    queue_due(r);
                end
            end
            r                 = '0;
            r.kind            = KIND_DECIDE;
            r.to_final        = (nh - 1 == pl);
            r.hop_error       = (nh > pl + 1);
            r.word_value      = r.to_final ? w.final_dest_ip : word;
            r.path_length_out = LEN_W'(pl);
            r.next_hop_out    = NH_W'(nh + 1);
            r.last            = 1'b1;
            queue_due(r);
        end
    endtask

    // Offer one word, hold it until accepted, then maybe idle
    task automatic send_word(input t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predict_forward(w);
        items_sent++;
        gap = (!quiet && $urandom_range(0, 1)) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Route update sequence: 0 whole, 1 abandoned part way, 2 key swapped at commit
    task automatic send_route(input logic [31:0] key, input int len, input int variant);
        int          eff;
        int          n;
        int          cut;
        int          idx;
        logic [31:0] k;
        eff = (len < MAX_HOPS) ? len : MAX_HOPS;
        n   = (eff == 0) ? 1 : eff;
        cut = (variant == 1 && n > 1) ? $urandom_range(1, n - 1) : n;
        for (idx = 0; idx < cut; idx++) begin
            k = (variant == 2 && idx == n - 1) ? route_keys[$urandom_range(0, KEY_POOL - 1)]
                                               : key;
            send_word(mk_hop(k, $urandom, idx, len));
        end
    endtask

    task automatic send_lookup(input logic [31:0] dest);
        t_in_word w;
        w = mk_packet(dest, $urandom, 0, $urandom_range(0, 15), $urandom);
        if (!lookup_safe(dest))
            w.next_hop_in = NH_W'($urandom_range(1, 15));
        send_word(w);
    endtask

    // Result checker
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_words.size() == 0) begin
                $error("result word with nothing expected: %p", o_out_data);
                fails++;
            end else begin
                want = due_words.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_out_data.kind));
                check_field("word_index", 32'(want.word_index),
                            32'(o_out_data.word_index));
                check_field("word_value",      want.word_value,      o_out_data.word_value);
                check_field("path_length_out", 32'(want.path_length_out),
                            32'(o_out_data.path_length_out));
                check_field("next_hop_out", 32'(want.next_hop_out),
                            32'(o_out_data.next_hop_out));
                check_field("to_final", 32'(want.to_final), 32'(o_out_data.to_final));
                check_field("hop_error", 32'(want.hop_error), 32'(o_out_data.hop_error));
                check_field("last", 32'(want.last), 32'(o_out_data.last));
                case (want.kind)
                    KIND_WORD:   path_words_seen++;
                    KIND_DECIDE: decisions_seen++;
                    KIND_COMMIT: commits_seen++;
                    default:     rejects_seen++;
                endcase
            end
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (quiet || $urandom_range(0, 99) < 65) begin
            i_out_ready <= 1'b1;
            ready_hold  = quiet ? 0 : $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold  = pick_gap();
        end
    end

    // Misses on an empty table at the address extremes
    task automatic test_lookup_miss();
        send_word(mk_packet(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF));
        send_word(mk_packet(32'hFFFF_FFFF, 32'h0000_0000, 0, 15, 32'h0000_0000));
    endtask

    // Packets that already carry a path
    task automatic test_carried_path();
        send_word(mk_packet($urandom, $urandom, 3, 2, $urandom));
        send_word(mk_packet($urandom, $urandom, 1, 4, $urandom));
        send_word(mk_packet($urandom, $urandom, 15, 15, 32'hFFFF_FFFF));
        send_word(mk_packet($urandom, $urandom, 12, 0, $urandom));
    endtask

    // Commit routes and read them back, including an empty and a full-length one
    task automatic test_route_table();
        send_route(route_keys[2], 3, 0);
        send_lookup(route_keys[2]);
        send_route(route_keys[3], 0, 0);
        send_lookup(route_keys[3]);
        send_route(route_keys[4], 15, 0);
        send_lookup(route_keys[4]);
    endtask

    // Rewrite an existing key and look it up while the update is open
    task automatic test_update_in_place();
        send_word(mk_hop(route_keys[2], $urandom, 0, 2));
        send_lookup(route_keys[2]);
        send_word(mk_hop(route_keys[2], $urandom, 1, 2));
        send_lookup(route_keys[2]);
        // Commit hop with no update open
        send_word(mk_hop($urandom, $urandom, 2, 3));
    endtask

    // Mixed traffic: mostly well-formed updates and lookups, some noise
    task automatic test_random_traffic();
        int          r;
        logic [31:0] dest;
        while (items_sent < RANDOM_TARGET) begin
            if ($urandom_range(0, 19) == 0)
                quiet = !quiet;
            r    = $urandom_range(0, 99);
            dest = ($urandom_range(0, 99) < 80) ? route_keys[$urandom_range(0, KEY_POOL - 1)]
                                                : $urandom;
            if (r < 35) begin
                send_route(dest,
                           ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                        : $urandom_range(9, 15),
                           ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 2));
            end else if (r < 70) begin
                send_lookup(dest);
            end else if (r < 90) begin
                send_word(mk_packet(dest, $urandom, $urandom_range(1, 15),
                                    ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                                 : $urandom_range(0, 15),
                                    $urandom));
            end else begin
                send_word(mk_hop(dest, $urandom, $urandom_range(0, 7), $urandom_range(0, 15)));
            end
        end
        quiet = 1'b0;
    endtask

    // Fill every slot, get a new key rejected, then keep using a full table
    task automatic test_table_full();
        int guard;
        int s;
        guard = 0;
        while (free_count() > 0 && guard < 40) begin
            send_route($urandom, $urandom_range(0, 2), 0);
            guard++;
        end
        send_route($urandom, 1, 0);
        for (guard = 0; guard < 5; guard++) begin
            s = $urandom_range(0, TABLE_ENTRIES - 1);
            send_route(route_key[s], $urandom_range(0, 3), 0);
            send_lookup(route_key[$urandom_range(0, TABLE_ENTRIES - 1)]);
        end
    endtask

    initial begin
        int k;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        fails       = 0;
        items_sent  = 0;
        lookup_hits = 0;
        quiet       = 1'b0;
        ready_hold  = 0;
        upd_slot    = 0;
        upd_ok      = 1'b0;
        route_keys[0] = 32'h0000_0000;
        route_keys[1] = 32'hFFFF_FFFF;
        for (k = 2; k < KEY_POOL; k++)
            route_keys[k] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lookup_miss();
        test_carried_path();
        test_route_table();
        test_update_in_place();
        test_random_traffic();
        test_table_full();

        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d route commits, %0d rejects, %0d table hits.",
                 items_sent, commits_seen, rejects_seen, lookup_hits);
        $display("Checked %0d forward decisions and %0d header path words.",
                 decisions_seen, path_words_seen);
        if (fails == 0)
            $display("source_route_table_forwarder_top test passed");
        else
            $display("source_route_table_forwarder_top test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("source_route_table_forwarder_top test failed");
        $finish;
    end

endmodule
